// ===== hw/rtl/pnr_pkg.sv =====
// Shared types and constants for the palette nearest-color remap block.
package pnr_pkg;

   localparam int unsigned CH_W      = 8;
   localparam int unsigned IDX_W     = 8;
   localparam int unsigned SIZE_W    = 9;
   localparam int unsigned DIST_W    = 10;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned REQ_W     = 48;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [CH_W-1:0]   CH_MAX   = 8'hFF;

   typedef enum logic [KIND_W-1:0] {
      KIND_OLD_LOAD = 2'd0,
      KIND_NEW_LOAD = 2'd1,
      KIND_PIXEL    = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OLD_SIZE = 2'd0,
      CSR_NEW_SIZE = 2'd1,
      CSR_DITHER   = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SEARCH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic start;
      logic step;
   } dist_ctl_type;

endpackage

// ===== hw/rtl/pnr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pnr_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pnr_dist.sv =====
// Shared Manhattan distance unit with running best-match tracking.
module pnr_dist
   import pnr_pkg::*;
#(
   parameter int unsigned AW = 8
) (
   input  logic          clock,
   input  dist_ctl_type  ctl,
   input  rgb_type       target,
   input  rgb_type       cand,
   input  logic [AW-1:0] cand_idx,
   output logic [AW-1:0] match_idx
);

   function automatic logic [CH_W-1:0] abs_diff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [DIST_W-1:0] cur_gap;
   logic [DIST_W-1:0] low_gap_ff, low_gap_in;
   logic [AW-1:0]     low_idx_ff, low_idx_in;

   always_comb begin
      cur_gap = DIST_W'(abs_diff(target.red, cand.red))
              + DIST_W'(abs_diff(target.green, cand.green))
              + DIST_W'(abs_diff(target.blue, cand.blue));
      low_gap_in = low_gap_ff;
      low_idx_in = low_idx_ff;
      if (ctl.start) begin
         low_gap_in = DIST_MAX;
         low_idx_in = '0;
      end else if (ctl.step && (cur_gap < low_gap_ff)) begin
         low_gap_in = cur_gap;
         low_idx_in = cand_idx;
      end
   end

   always_ff @(posedge clock) begin
      low_gap_ff <= low_gap_in;
      low_idx_ff <= low_idx_in;
   end

   assign match_idx = low_idx_ff;

endmodule

// ===== hw/rtl/palette_nearest_remap.sv =====
// Top level: remaps old-palette pixel indexes to the nearest new-palette entry.
// Load transaction: writes one palette entry; requests are accepted only while idle.
// Pixel transaction: the old-palette color is fetched, then all N new entries are searched
//   (N = effective new palette size) and the best index emitted; one new-palette entry is compared per cycle.
// Empty old or new palette: the pixel index is emitted without a search; a held result stalls emit.
// Synchronous reset clears control and size/dither registers; palette RAMs are not cleared.
module palette_nearest_remap
   import pnr_pkg::*;
#(
   parameter int unsigned PALETTE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // entry_index, red, green, blue, pixel_value, dither_offset
   input  logic [REQ_W-1:0]     req_tdata,
   // kind
   input  logic [KIND_W-1:0]    req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // new_index
   output logic [IDX_W-1:0]     rsp_tdata,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata
);

   localparam int unsigned AW = $clog2(PALETTE_DEPTH);
   localparam logic [SIZE_W-1:0] DEPTH_SZ = SIZE_W'(PALETTE_DEPTH);

   function automatic logic [CH_W-1:0] clamp_chan(logic [CH_W-1:0] c,
                                                  logic signed [CH_W-1:0] off);
      logic signed [CH_W+1:0] sum;
      sum = $signed({2'b00, c}) + $signed({{2{off[CH_W-1]}}, off});
      if (sum < 0) begin
         return '0;
      end else if (sum > $signed({2'b00, CH_MAX})) begin
         return CH_MAX;
      end else begin
         return sum[CH_W-1:0];
      end
   endfunction

   state_type           state_ff, state_in;
   logic [SIZE_W-1:0]   old_size_ff, old_size_in;
   logic [SIZE_W-1:0]   new_size_ff, new_size_in;
   logic                dither_ff, dither_in;
   logic [IDX_W-1:0]    pix_ff, pix_in;
   logic signed [CH_W-1:0] off_ff, off_in;
   logic                old_hit_ff, old_hit_in;
   logic                bypass_ff, bypass_in;
   logic [AW-1:0]       last_ff, last_in;
   logic [AW-1:0]       cmp_ff, cmp_in;
   rgb_type             target_ff, target_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]    f_entry, f_pixel;
   rgb_type             f_rgb;
   logic signed [CH_W-1:0] f_off;
   logic [SIZE_W-1:0]   osz_eff, nsz_eff;
   logic                accept, wr_ok;
   logic                old_we, new_we;
   logic [AW-1:0]       old_raddr, new_raddr;
   rgb_type             old_rdata, new_rdata, color;
   dist_ctl_type        dist_ctl;
   logic [AW-1:0]       match_idx;

   assign f_entry   = req_tdata[7:0];
   assign f_rgb     = {req_tdata[15:8], req_tdata[23:16], req_tdata[31:24]};
   assign f_pixel   = req_tdata[39:32];
   assign f_off     = $signed(req_tdata[47:40]);

   assign osz_eff   = (old_size_ff > DEPTH_SZ) ? DEPTH_SZ : old_size_ff;
   assign nsz_eff   = (new_size_ff > DEPTH_SZ) ? DEPTH_SZ : new_size_ff;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept    = req_tvalid && req_tready;
   assign wr_ok     = {1'b0, f_entry} < DEPTH_SZ;
   assign old_raddr = f_pixel[AW-1:0];

   always_comb begin
      old_size_in = old_size_ff;
      new_size_in = new_size_ff;
      dither_in   = dither_ff;
      if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_OLD_SIZE: old_size_in = csr_wdata;
            CSR_NEW_SIZE: new_size_in = csr_wdata;
            CSR_DITHER:   dither_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      pix_in       = pix_ff;
      off_in       = off_ff;
      old_hit_in   = old_hit_ff;
      bypass_in    = bypass_ff;
      last_in      = last_ff;
      cmp_in       = cmp_ff;
      target_in    = target_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      old_we       = 1'b0;
      new_we       = 1'b0;
      new_raddr    = cmp_ff + AW'(1);
      dist_ctl     = '0;
      color        = old_hit_ff ? old_rdata : '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (kind_type'(req_tuser))
                  KIND_OLD_LOAD: old_we = wr_ok;
                  KIND_NEW_LOAD: new_we = wr_ok;
                  KIND_PIXEL: begin
                     pix_in     = f_pixel;
                     off_in     = f_off;
                     old_hit_in = {1'b0, f_pixel} < osz_eff;
                     last_in    = AW'(nsz_eff - SIZE_W'(1));
                     if ((osz_eff == '0) || (nsz_eff == '0)) begin
                        bypass_in = 1'b1;
                        state_in  = ST_EMIT;
                     end else begin
                        bypass_in = 1'b0;
                        state_in  = ST_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            if (dither_ff) begin
               target_in.red   = clamp_chan(color.red, off_ff);
               target_in.green = clamp_chan(color.green, off_ff);
               target_in.blue  = clamp_chan(color.blue, off_ff);
            end else begin
               target_in = color;
            end
            dist_ctl.start = 1'b1;
            new_raddr      = '0;
            cmp_in         = '0;
            state_in       = ST_SEARCH;
         end
         ST_SEARCH: begin
            dist_ctl.step = 1'b1;
            cmp_in        = cmp_ff + AW'(1);
            if (cmp_ff == last_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = bypass_ff ? pix_ff : IDX_W'(match_idx);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         old_size_ff  <= '0;
         new_size_ff  <= '0;
         dither_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         old_size_ff  <= old_size_in;
         new_size_ff  <= new_size_in;
         dither_ff    <= dither_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      off_ff      <= off_in;
      old_hit_ff  <= old_hit_in;
      bypass_ff   <= bypass_in;
      last_ff     <= last_in;
      cmp_ff      <= cmp_in;
      target_ff   <= target_in;
      rsp_data_ff <= rsp_data_in;
   end

   pnr_ram #(
      .WIDTH ($bits(rgb_type)),
      .DEPTH (PALETTE_DEPTH)
   ) u_old_ram (
      .clock   (clock),
      .wr_en   (old_we),
      .wr_addr (f_entry[AW-1:0]),
      .wr_data (f_rgb),
      .rd_addr (old_raddr),
      .rd_data (old_rdata)
   );

   pnr_ram #(
      .WIDTH ($bits(rgb_type)),
      .DEPTH (PALETTE_DEPTH)
   ) u_new_ram (
      .clock   (clock),
      .wr_en   (new_we),
      .wr_addr (f_entry[AW-1:0]),
      .wr_data (f_rgb),
      .rd_addr (new_raddr),
      .rd_data (new_rdata)
   );

   pnr_dist #(
      .AW (AW)
   ) u_dist (
      .clock     (clock),
      .ctl       (dist_ctl),
      .target    (target_ff),
      .cand      (new_rdata),
      .cand_idx  (cmp_ff),
      .match_idx (match_idx)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside emit");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (cmp_ff <= last_ff))
      else $error("search index past palette end");

   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !bypass_ff) |-> (match_idx <= last_ff))
      else $error("best index outside searched range");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |=> (state_ff == ST_SEARCH || state_ff == ST_EMIT))
      else $error("search left without emitting");

endmodule
